// ===== sv/cpc_sketch_coupon_update_unit_defines.svh =====
// assertion macros for the coupon update unit
`ifndef CPC_SKETCH_COUPON_UPDATE_UNIT_DEFINES_SVH
`define CPC_SKETCH_COUPON_UPDATE_UNIT_DEFINES_SVH

// same-cycle implication
`define CPC_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CPC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/cpc_pkg.sv =====
// shared constants, types and helpers for the coupon update unit
package cpc_pkg;

	localparam int MAX_LG_K_DEF = 12;
	localparam int LG_K_MIN     = 4;
	localparam int LG_K_RESET   = 12;
	localparam int FRAC_BITS    = 24;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic REG_LG_K = 1'b0;

	localparam logic [2:0] FLV_EMPTY   = 3'd0;
	localparam logic [2:0] FLV_SPARSE  = 3'd1;
	localparam logic [2:0] FLV_HYBRID  = 3'd2;
	localparam logic [2:0] FLV_PINNED  = 3'd3;
	localparam logic [2:0] FLV_SLIDING = 3'd4;

	typedef struct packed {
		logic       novel;
		logic [5:0] col;
	} cpc_entry_t;

	typedef enum logic [1:0] {F_CLEAR, F_IDLE, F_CHECK} front_state_t;
	typedef enum logic [2:0] {B_IDLE, B_DIV, B_MUL, B_ERR, B_ACC} back_state_t;

	// leading zero count clipped to 63, binary search in six steps
	function automatic logic [5:0] lead_col(input logic [63:0] v);
		logic [63:0] x;
		logic [6:0]  n;
		x = v;
		n = '0;
		if (x[63:32] == 32'd0) begin n = n + 7'd32; x = {x[31:0], 32'd0}; end
		if (x[63:48] == 16'd0) begin n = n + 7'd16; x = {x[47:0], 16'd0}; end
		if (x[63:56] == 8'd0) begin n = n + 7'd8; x = {x[55:0], 8'd0}; end
		if (x[63:60] == 4'd0) begin n = n + 7'd4; x = {x[59:0], 4'd0}; end
		if (x[63:62] == 2'd0) begin n = n + 7'd2; x = {x[61:0], 2'd0}; end
		if (!x[63]) n = n + 7'd1;
		return (n > 7'd63) ? 6'd63 : n[5:0];
	endfunction

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

endpackage

// ===== sv/cpc_front.sv =====
// front end: coupon matrix lookup, novelty check and clearing sweep
module cpc_front #(
	parameter int MAX_LG_K = cpc_pkg::MAX_LG_K_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clear,
	input  logic [$clog2(MAX_LG_K+1)-1:0]      lg_k,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [127:0]                       s_tdata,
	input  logic                               q_full,
	output logic                               push,
	output cpc_pkg::cpc_entry_t                push_data
);
	localparam int ROWS = 1 << MAX_LG_K;

	cpc_pkg::front_state_t state_q, state_d;
	logic [MAX_LG_K-1:0] clr_addr_q;
	logic [MAX_LG_K-1:0] row_q;
	logic [5:0]          col_q;
	logic [63:0]         rd_q;
	logic [63:0]         mem_q [ROWS];

	logic [MAX_LG_K-1:0] row_mask, row_in;
	logic                wr_en;
	logic [MAX_LG_K-1:0] wr_addr;
	logic [63:0]         wr_data;
	logic                novel;

	assign row_mask = ~({MAX_LG_K{1'b1}} << lg_k);
	assign row_in   = s_tdata[MAX_LG_K-1:0] & row_mask;
	assign novel    = !rd_q[col_q];
	assign push_data = '{novel: novel, col: col_q};

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		push     = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = clr_addr_q;
		wr_data  = '0;
		unique case (state_q)
			cpc_pkg::F_CLEAR: begin
				wr_en = 1'b1;
				if (clr_addr_q == {MAX_LG_K{1'b1}}) state_d = cpc_pkg::F_IDLE;
			end
			cpc_pkg::F_IDLE: begin
				s_tready = !q_full;
				if (s_tvalid && !q_full) state_d = cpc_pkg::F_CHECK;
			end
			cpc_pkg::F_CHECK: begin
				push = 1'b1;
				if (novel) begin
					wr_en   = 1'b1;
					wr_addr = row_q;
					wr_data = rd_q | (64'd1 << col_q);
				end
				state_d = cpc_pkg::F_IDLE;
			end
			default: state_d = cpc_pkg::F_CLEAR;
		endcase
		if (clear) state_d = cpc_pkg::F_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cpc_pkg::F_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (clear) clr_addr_q <= '0;
			else if (state_q == cpc_pkg::F_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			row_q <= row_in;
			col_q <= cpc_pkg::lead_col(s_tdata[127:64]);
			rd_q  <= mem_q[row_in];
		end
		if (wr_en) mem_q[wr_addr] <= wr_data;
	end
endmodule

// ===== sv/cpc_fifo.sv =====
// short queue of classified words between front and back
module cpc_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cpc_pkg::cpc_entry_t push_data,
	output logic                full,
	input  logic                pop,
	output cpc_pkg::cpc_entry_t pop_data,
	output logic                empty
);
	localparam int AW = $clog2(cpc_pkg::QUEUE_DEPTH);

	cpc_pkg::cpc_entry_t ent_q [cpc_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;

	assign full     = (cnt_q == (AW+1)'(cpc_pkg::QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_data;
	end
endmodule

// ===== sv/cpc_back.sv =====
// back end: coupon count, serial hip divider, error term and result register
module cpc_back #(
	parameter int MAX_LG_K = cpc_pkg::MAX_LG_K_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic [$clog2(MAX_LG_K+1)-1:0] lg_next,
	input  logic [$clog2(MAX_LG_K+1)-1:0] lg_k,
	input  logic                          q_empty,
	output logic                          pop,
	input  cpc_pkg::cpc_entry_t           pop_data,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [151:0]                  m_tdata
);
	localparam int LGW  = $clog2(MAX_LG_K+1);
	localparam int WW   = MAX_LG_K + 1;
	localparam int DW   = WW + 64;
	localparam int CNTW = MAX_LG_K + 7;
	localparam int FW   = CNTW + 5;
	localparam int TOPX = 64 + cpc_pkg::FRAC_BITS;
	localparam int CW   = $clog2(MAX_LG_K + TOPX + 1);
	localparam int LG_R = (cpc_pkg::LG_K_RESET > MAX_LG_K) ? MAX_LG_K : cpc_pkg::LG_K_RESET;

	cpc_pkg::back_state_t state_q, state_d;

	logic [63:0]     hip_q, herr_q;
	logic [DW-1:0]   kxp_q;
	logic [CNTW-1:0] cnt_q;
	logic [5:0]      col_q;
	logic [DW-1:0]   rem_q;
	logic [63:0]     quo_q;
	logic            sat_q, first_q;
	logic [CW-1:0]   it_q;
	logic [2:0]      mc_q;
	logic [63:0]     pp_q;
	logic [127:0]    prod_q;
	logic [63:0]     e_q;

	logic            ov_q, onov_q;
	logic [18:0]     ocnt_q;
	logic [2:0]      oflv_q;
	logic [63:0]     oest_q, oerr_q;

	logic            out_free, load;
	logic [DW:0]     rem_sh, div_ext, rem_n;
	logic            ge;
	logic [63:0]     qf, hip_n, herr_n;
	logic [31:0]     mul_a, mul_b;
	logic [63:0]     err_v;
	logic [CNTW-1:0] cnt_inc;

	function automatic logic [2:0] flavor(input logic [CNTW-1:0] c, input logic [LGW-1:0] lg);
		logic [FW-1:0] k, cx;
		k  = FW'(1) << lg;
		cx = FW'(c);
		if (c == '0) return cpc_pkg::FLV_EMPTY;
		if ((cx << 5) < (k << 1) + k) return cpc_pkg::FLV_SPARSE;
		if ((cx << 1) < k) return cpc_pkg::FLV_HYBRID;
		if ((cx << 3) < k * FW'(27)) return cpc_pkg::FLV_PINNED;
		return cpc_pkg::FLV_SLIDING;
	endfunction

	assign out_free = !ov_q || m_tready;
	assign rem_sh   = {rem_q, first_q};
	assign div_ext  = {1'b0, kxp_q};
	assign ge       = rem_sh >= div_ext;
	assign rem_n    = ge ? rem_sh - div_ext : rem_sh;
	assign qf       = sat_q ? '1 : quo_q;
	assign hip_n    = cpc_pkg::add_sat(hip_q, qf);
	assign herr_n   = cpc_pkg::add_sat(herr_q, e_q);
	assign mul_a    = mc_q[1] ? qf[63:32] : qf[31:0];
	assign mul_b    = mc_q[0] ? qf[63:32] : qf[31:0];
	assign err_v    = prod_q[cpc_pkg::FRAC_BITS+63:cpc_pkg::FRAC_BITS];
	assign cnt_inc  = cnt_q + 1'b1;

	assign m_tvalid = ov_q;
	// novel, count, flavor, estimate, error sum from bit 0 up
	assign m_tdata  = {1'b0, oerr_q, oest_q, oflv_q, ocnt_q, onov_q};

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		unique case (state_q)
			cpc_pkg::B_IDLE: begin
				if (!q_empty && out_free) begin
					pop = 1'b1;
					if (pop_data.novel) state_d = cpc_pkg::B_DIV;
					else load = 1'b1;
				end
			end
			cpc_pkg::B_DIV: if (it_q == '0) state_d = cpc_pkg::B_MUL;
			cpc_pkg::B_MUL: if (mc_q == 3'd4) state_d = cpc_pkg::B_ERR;
			cpc_pkg::B_ERR: state_d = cpc_pkg::B_ACC;
			cpc_pkg::B_ACC: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = cpc_pkg::B_IDLE;
				end
			end
			default: state_d = cpc_pkg::B_IDLE;
		endcase
		if (clear) state_d = cpc_pkg::B_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpc_pkg::B_IDLE;
			ov_q    <= 1'b0;
			hip_q   <= '0;
			herr_q  <= '0;
			kxp_q   <= {WW'(1) << LG_R, 64'd0};
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;
			if (clear) begin
				hip_q  <= '0;
				herr_q <= '0;
				kxp_q  <= {WW'(1) << lg_next, 64'd0};
				cnt_q  <= '0;
			end else if (state_q == cpc_pkg::B_ACC && out_free) begin
				hip_q  <= hip_n;
				herr_q <= herr_n;
				// kxp -= 2^-(col+1), exact in 64 fraction bits
				kxp_q  <= kxp_q - (DW'(1) << (~col_q));
				cnt_q  <= cnt_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cpc_pkg::B_IDLE: begin
				col_q   <= pop_data.col;
				rem_q   <= '0;
				quo_q   <= '0;
				sat_q   <= 1'b0;
				first_q <= 1'b1;
				it_q    <= CW'(lg_k) + CW'(TOPX);
				mc_q    <= '0;
				prod_q  <= '0;
			end
			cpc_pkg::B_DIV: begin
				rem_q   <= rem_n[DW-1:0];
				sat_q   <= sat_q | quo_q[63];
				quo_q   <= {quo_q[62:0], ge};
				first_q <= 1'b0;
				it_q    <= it_q - 1'b1;
			end
			cpc_pkg::B_MUL: begin
				if (mc_q != 3'd4) pp_q <= mul_a * mul_b;
				case (mc_q)
					3'd1: prod_q <= prod_q + 128'(pp_q);
					3'd2, 3'd3: prod_q <= prod_q + (128'(pp_q) << 32);
					3'd4: prod_q <= prod_q + (128'(pp_q) << 64);
					default: prod_q <= prod_q;
				endcase
				mc_q <= mc_q + 1'b1;
			end
			cpc_pkg::B_ERR: begin
				if (|prod_q[127:cpc_pkg::FRAC_BITS+64]) e_q <= '1;
				else e_q <= (err_v < qf) ? 64'd0 : err_v - qf;
			end
			default: ;
		endcase
		if (load) begin
			if (state_q == cpc_pkg::B_ACC) begin
				onov_q <= 1'b1;
				ocnt_q <= 19'(cnt_inc);
				oflv_q <= flavor(cnt_inc, lg_k);
				oest_q <= hip_n;
				oerr_q <= herr_n;
			end else begin
				onov_q <= 1'b0;
				ocnt_q <= 19'(cnt_q);
				oflv_q <= flavor(cnt_q, lg_k);
				oest_q <= hip_q;
				oerr_q <= herr_q;
			end
		end
	end
endmodule

// ===== sv/cpc_sketch_coupon_update_unit.sv =====
// top level of the coupon update unit with its register port
// Each input word (two 64-bit hashes) selects one bit of a coupon matrix held in an on-chip
// memory of 2^MAX_LG_K rows by 64 bits. The front end reads the memory row, then checks and
// writes back, and queues the word; a repeated coupon goes from the queue straight to the output
// register, while a novel coupon runs the bit-serial HIP divider and a 32x32 multiplier that sums
// four partial products for the error term. After reset and after every write of lg_k the matrix
// is swept clear, one row per cycle over all 2^MAX_LG_K rows, and no word is taken meanwhile.
// Results come out in order with one output register.
`include "cpc_sketch_coupon_update_unit_defines.svh"
module cpc_sketch_coupon_update_unit #(
	parameter int MAX_LG_K = cpc_pkg::MAX_LG_K_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // hash_low, hash_high
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [151:0] m_tdata,  // is_novel, coupon_total, flavor_code, distinct_estimate,
	                               // error_sum, zero pad
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	localparam int LGW  = $clog2(MAX_LG_K+1);
	localparam int LG_R = (cpc_pkg::LG_K_RESET > MAX_LG_K) ? MAX_LG_K : cpc_pkg::LG_K_RESET;

	logic [LGW-1:0] lg_k_q, lg_next;
	logic           cfg_wr;
	logic           q_push, q_pop, q_full, q_empty;
	cpc_pkg::cpc_entry_t push_data, pop_data;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == cpc_pkg::REG_LG_K);
	assign prdata = (paddr[2] == cpc_pkg::REG_LG_K) ? 32'(lg_k_q) : 32'd0;

	always_comb begin
		if (pwdata < 32'(cpc_pkg::LG_K_MIN)) lg_next = LGW'(cpc_pkg::LG_K_MIN);
		else if (pwdata > 32'(MAX_LG_K)) lg_next = LGW'(MAX_LG_K);
		else lg_next = pwdata[LGW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lg_k_q <= LGW'(LG_R);
		else if (cfg_wr) lg_k_q <= lg_next;
	end

	cpc_front #(.MAX_LG_K(MAX_LG_K)) u_front (
		.clk(clk), .arst_n(arst_n), .clear(cfg_wr), .lg_k(lg_k_q),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.q_full(q_full), .push(q_push), .push_data(push_data)
	);

	cpc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_data(push_data), .full(q_full),
		.pop(q_pop), .pop_data(pop_data), .empty(q_empty)
	);

	cpc_back #(.MAX_LG_K(MAX_LG_K)) u_back (
		.clk(clk), .arst_n(arst_n), .clear(cfg_wr), .lg_next(lg_next), .lg_k(lg_k_q),
		.q_empty(q_empty), .pop(q_pop), .pop_data(pop_data),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	`CPC_ASSERT_NEXT(a_clear_blocks_input, clk, arst_n, cfg_wr, !s_tready, "input taken during clear")
	`CPC_ASSERT_SAME(a_no_overflow, clk, arst_n, q_push, !q_full, "queue overflow")
	`CPC_ASSERT_SAME(a_no_underflow, clk, arst_n, q_pop, !q_empty, "queue underflow")
endmodule

// ===== tb/tb_cpc_sketch_coupon_update_unit.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the coupon update unit with its own hip estimator model
module tb_cpc_sketch_coupon_update_unit;

	localparam int          CLK_PERIOD = 12;
	localparam int          WD_LIMIT   = 30000;
	localparam int          SETTLE     = 250;
	localparam logic [2:0]  ADDR_LG_K  = 3'(4 * cpc_pkg::REG_LG_K);
	localparam logic [2:0]  ADDR_SPARE = 3'd4;

	typedef struct packed {
		logic        novel;
		logic [18:0] total;
		logic [2:0]  flavor;
		logic [63:0] estimate;
		logic [63:0] err_sum;
	} coupon_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;  // hash_low, hash_high
	logic         m_tvalid;
	logic         m_tready;
	logic [151:0] m_tdata;  // is_novel, coupon_total, flavor_code, distinct_estimate,
	                        // error_sum, zero pad
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	cpc_sketch_coupon_update_unit dut (.*);

	// model state
	logic [63:0]    coupon_rows [0:4095];
	logic [18:0]    coupons_seen;
	logic [76:0]    kxp_raw;  // 13 whole bits, 64 fraction bits
	logic [63:0]    hip_est;
	logic [63:0]    hip_err;
	int unsigned    lg_rows;
	coupon_result_t pending_results[$];

	int unsigned fail_count;
	int unsigned words_in;
	int unsigned words_out;
	int unsigned novel_out;
	int unsigned idle_cycles;
	bit          quiet;      // no gaps on either side
	bit          hold_req;   // receiver long hold-off

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic int unsigned clip_lg(input logic [31:0] v);
		if (v < cpc_pkg::LG_K_MIN) return cpc_pkg::LG_K_MIN;
		if (v > cpc_pkg::MAX_LG_K_DEF) return cpc_pkg::MAX_LG_K_DEF;
		return v;
	endfunction

	function automatic void clear_model();
		foreach (coupon_rows[i]) coupon_rows[i] = '0;
		coupons_seen = '0;
		kxp_raw = 77'(1) << (lg_rows + 64);
		hip_est = '0;
		hip_err = '0;
	endfunction

	function automatic logic [2:0] flavor_for(input logic [18:0] c);
		logic [31:0] k;
		logic [31:0] cw;
		k = 32'(1) << lg_rows;
		cw = 32'(c);
		if (cw == 0) return cpc_pkg::FLV_EMPTY;
		if ((cw << 5) < 3 * k) return cpc_pkg::FLV_SPARSE;
		if ((cw << 1) < k) return cpc_pkg::FLV_HYBRID;
		if ((cw << 3) < 27 * k) return cpc_pkg::FLV_PINNED;
		return cpc_pkg::FLV_SLIDING;
	endfunction

	function automatic coupon_result_t update_coupon(input logic [63:0] h_lo,
			input logic [63:0] h_hi);
		int unsigned    row;
		int unsigned    col;
		logic [127:0]   quot;
		logic [127:0]   sq;
		logic [63:0]    inv_p;
		logic [63:0]    err_term;
		coupon_result_t r;
		row = h_lo & ((64'(1) << lg_rows) - 1);
		col = 0;
		while (col < 63 && !h_hi[63 - col]) col++;
		r.novel = 1'b0;
		if (!coupon_rows[row][col]) begin
			r.novel = 1'b1;
			coupon_rows[row][col] = 1'b1;
			coupons_seen++;
			quot = (128'(1) << (lg_rows + 64 + cpc_pkg::FRAC_BITS)) / 128'(kxp_raw);
			inv_p = (quot[127:64] != 0) ? '1 : quot[63:0];
			sq = 128'(inv_p) * 128'(inv_p);
			sq = sq >> cpc_pkg::FRAC_BITS;
			if (sq[127:64] != 0) err_term = '1;
			else err_term = (sq[63:0] < inv_p) ? '0 : sq[63:0] - inv_p;
			hip_est = cpc_pkg::add_sat(hip_est, inv_p);
			hip_err = cpc_pkg::add_sat(hip_err, err_term);
			kxp_raw = kxp_raw - (77'(1) << (63 - col));
		end
		r.total = coupons_seen;
		r.flavor = flavor_for(coupons_seen);
		r.estimate = hip_est;
		r.err_sum = hip_err;
		return r;
	endfunction

	// prediction on every accepted input word
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			pending_results.push_back(update_coupon(s_tdata[63:0], s_tdata[127:64]));
			words_in++;
		end
	end

	// result checker
	always @(posedge clk) begin
		coupon_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			words_out++;
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (exp_r.novel) novel_out++;
				if (m_tdata[0] !== exp_r.novel) begin
					$error("is_novel: expected %0d, got %0d", exp_r.novel, m_tdata[0]);
					fail_count++;
				end
				if (m_tdata[19:1] !== exp_r.total) begin
					$error("coupon_total: expected %0d, got %0d", exp_r.total, m_tdata[19:1]);
					fail_count++;
				end
				if (m_tdata[22:20] !== exp_r.flavor) begin
					$error("flavor_code: expected %0d, got %0d", exp_r.flavor, m_tdata[22:20]);
					fail_count++;
				end
				if (m_tdata[86:23] !== exp_r.estimate) begin
					$error("distinct_estimate: expected %h, got %h", exp_r.estimate,
						m_tdata[86:23]);
					fail_count++;
				end
				if (m_tdata[150:87] !== exp_r.err_sum) begin
					$error("error_sum: expected %h, got %h", exp_r.err_sum, m_tdata[150:87]);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any word moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("cpc_sketch_coupon_update_unit regression: fail");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
			end
			stall = quiet ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	task automatic send_hash(input logic [63:0] h_lo, input logic [63:0] h_hi);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {h_hi, h_lo};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		wait_idle();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_LG_K) begin
			lg_rows = clip_lg(value);
			clear_model();
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// column spread: shift a random word so every leading-zero count shows up
	function automatic logic [63:0] rand_col_hash();
		if ($urandom_range(0, 31) == 0) return '0;
		return rand_word() >> $urandom_range(0, 63);
	endfunction

	task automatic test_directed();
		send_hash('0, '0);
		send_hash('0, '0);                         // repeated coupon
		send_hash('1, '1);                         // last row, column zero
		send_hash('1, 64'd1);                      // column 63 from the lsb
		send_hash(64'hffff_ffff_ffff_f000, 64'h8000_0000_0000_0000);
		send_hash(64'h0000_0000_0000_0fff, 64'h0000_0001_0000_0000);
		send_hash(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
		send_hash(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
		send_hash('1, '0);
		send_hash('1, '0);
	endtask

	task automatic test_config_clip();
		reg_write(ADDR_LG_K, 32'd0);                // clips up to the minimum
		for (int i = 0; i < 12; i++) send_hash(64'(i), 64'(1) << (63 - i));
		send_hash('1, '1);
		reg_write(ADDR_SPARE, 32'd7);               // unmapped, sketch must survive
		send_hash('1, '1);
		reg_write(ADDR_LG_K, 32'hffff_ffff);       // clips down to the maximum
		send_hash('1, '0);
		send_hash('0, '1);
	endtask

	task automatic test_random(input logic [31:0] lg_val, input int unsigned count);
		reg_write(ADDR_LG_K, lg_val);
		for (int i = 0; i < count; i++) begin
			quiet = (i % 100) >= 85;
			send_hash(rand_word(), rand_col_hash());
		end
		quiet = 1'b0;
	endtask

	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int i = 0; i < 20; i++) send_hash(rand_word(), rand_col_hash());
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fail_count = 0;
		words_in = 0;
		words_out = 0;
		novel_out = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		lg_rows = clip_lg(cpc_pkg::LG_K_RESET);
		clear_model();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_config_clip();
		test_random(32'd4, 320);
		test_backpressure();
		test_random(32'd8, 260);
		test_random(32'd5, 220);
		test_random(32'd12, 260);
		wait_idle();
		$display("coupon update run: %0d hash words in, %0d results checked, %0d novel",
			words_in, words_out, novel_out);
		$display("covered lg_k 4, 5, 8, 12 with clipping, an unmapped write and a long stall");
		if (fail_count == 0 && pending_results.size() == 0)
			$display("cpc_sketch_coupon_update_unit regression: pass");
		else
			$display("cpc_sketch_coupon_update_unit regression: fail");
		$finish;
	end

endmodule
